### src/elastic_collision_velocity_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elastic collision velocity block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_VELOCITY_TOP_ASSERT_SVH
`define ELASTIC_COLLISION_VELOCITY_TOP_ASSERT_SVH

// same-cycle implication
`define ECV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define ECV_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

### src/ecv_pkg.sv
// ----------------------------------------------------------------------------
// ecv_pkg
// Widths, payload types and limits for the elastic collision velocity block.
// ----------------------------------------------------------------------------
package ecv_pkg;

  localparam int VelW  = 16;            // signed Q8.8 velocity
  localparam int SizeW = 8;             // side length
  localparam int SqW   = 2 * SizeW;     // squared side (mass)
  localparam int TotW  = SqW + 1;       // mass sum, doubled mass
  localparam int NumW  = TotW + VelW;   // numerator magnitude
  localparam int QuoW  = VelW + 1;      // quotient magnitude, below 3 * 2^(VelW-1)

  localparam int FrontDepth = 5;
  localparam int Latency    = FrontDepth + QuoW + 1;

  localparam logic [QuoW-1:0] LimNeg = QuoW'(1) << (VelW - 1);
  localparam logic [QuoW-1:0] LimPos = LimNeg - QuoW'(1);

  localparam logic signed [VelW-1:0] VelMax = VelW'(LimPos);
  localparam logic signed [VelW-1:0] VelMin = VelW'(LimNeg);

  typedef struct packed {
    logic                    func;
    logic [SizeW-1:0]        size_a;
    logic [SizeW-1:0]        size_b;
    logic signed [VelW-1:0]  vel_a_x;
    logic signed [VelW-1:0]  vel_a_y;
    logic signed [VelW-1:0]  vel_b_x;
    logic signed [VelW-1:0]  vel_b_y;
  } ecv_in_t;

  typedef struct packed {
    logic signed [VelW-1:0]  new_vel_a;
    logic signed [VelW-1:0]  new_vel_b;
    logic                    clipped;
  } ecv_out_t;

  // divider work word for both bodies, sign-magnitude
  typedef struct packed {
    logic             neg_a;
    logic             neg_b;
    logic [NumW-1:0]  rem_a;
    logic [NumW-1:0]  rem_b;
    logic [QuoW-1:0]  quo_a;
    logic [QuoW-1:0]  quo_b;
    logic [TotW-1:0]  den;
  } ecv_div_t;

endpackage

### src/ecv_front.sv
// ----------------------------------------------------------------------------
// ecv_front
// Axis select, masses, weighted terms and signed numerators in five stages.
// ----------------------------------------------------------------------------
module ecv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ecv_pkg::ecv_in_t  item_i,
  output logic              valid_o,
  output ecv_pkg::ecv_div_t div_o
);
  import ecv_pkg::*;

  // sign-magnitude sum of two terms, result {neg, mag}
  function automatic logic [NumW:0] combine(logic n1, logic [NumW-1:0] m1,
                                            logic n2, logic [NumW-1:0] m2);
    logic [NumW:0] r;
    if (n1 == n2) begin
      r = {n1, m1 + m2};
    end else if (m1 >= m2) begin
      r = {n1, m1 - m2};
    end else begin
      r = {n2, m2 - m1};
    end
    return r;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1: axis select
  logic [SizeW-1:0] a1_q, b1_q;
  logic [VelW-1:0]  ua1_q, ub1_q;

  // stage 2: squares
  logic [SqW-1:0]   sa2_q, sb2_q, sa2_d, sb2_d;
  logic [VelW-1:0]  ua2_q, ub2_q;

  // stage 3: sums, differences, magnitudes
  logic [TotW-1:0]  tot3_q, twa3_q, twb3_q, tot3_d;
  logic [SqW-1:0]   dmag3_q, dmag3_d;
  logic             dneg3_q, dneg3_d;
  logic [VelW-1:0]  mua3_q, mub3_q, mua3_d, mub3_d;
  logic             nua3_q, nub3_q;

  // stage 4: products
  logic [NumW-1:0]  p1a4_q, p2a4_q, p1b4_q, p2b4_q;
  logic [NumW-1:0]  p1a4_d, p2a4_d, p1b4_d, p2b4_d;
  logic             n1a4_q, n2a4_q, n1b4_q, n2b4_q;
  logic             zero4_q;
  logic [TotW-1:0]  tot4_q;
  logic [VelW-1:0]  mua4_q, mub4_q;
  logic             nua4_q, nub4_q;

  // stage 5: numerators
  ecv_div_t         div5_q, div5_d;
  logic [NumW:0]    num_a, num_b;

  assign sa2_d = SqW'(a1_q) * SqW'(a1_q);
  assign sb2_d = SqW'(b1_q) * SqW'(b1_q);

  assign tot3_d  = TotW'(sa2_q) + TotW'(sb2_q);
  assign dneg3_d = sa2_q < sb2_q;
  assign dmag3_d = dneg3_d ? (sb2_q - sa2_q) : (sa2_q - sb2_q);
  assign mua3_d  = ua2_q[VelW-1] ? VelW'(~ua2_q + VelW'(1)) : ua2_q;
  assign mub3_d  = ub2_q[VelW-1] ? VelW'(~ub2_q + VelW'(1)) : ub2_q;

  assign p1a4_d = NumW'(dmag3_q) * NumW'(mua3_q);
  assign p2a4_d = NumW'(twb3_q)  * NumW'(mub3_q);
  assign p1b4_d = NumW'(twa3_q)  * NumW'(mua3_q);
  assign p2b4_d = NumW'(dmag3_q) * NumW'(mub3_q);

  assign num_a = combine(n1a4_q, p1a4_q, n2a4_q, p2a4_q);
  assign num_b = combine(n1b4_q, p1b4_q, n2b4_q, p2b4_q);

  always_comb begin
    div5_d       = '0;
    if (zero4_q) begin
      // both bodies massless: divide by one to pass velocities through
      div5_d.den   = TotW'(1);
      div5_d.rem_a = NumW'(mua4_q);
      div5_d.rem_b = NumW'(mub4_q);
      div5_d.neg_a = nua4_q;
      div5_d.neg_b = nub4_q;
    end else begin
      div5_d.den   = tot4_q;
      div5_d.rem_a = num_a[NumW-1:0];
      div5_d.rem_b = num_b[NumW-1:0];
      div5_d.neg_a = num_a[NumW];
      div5_d.neg_b = num_b[NumW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= item_i.size_a;
    b1_q    <= item_i.size_b;
    ua1_q   <= item_i.func ? item_i.vel_a_y : item_i.vel_a_x;
    ub1_q   <= item_i.func ? item_i.vel_b_y : item_i.vel_b_x;

    sa2_q   <= sa2_d;
    sb2_q   <= sb2_d;
    ua2_q   <= ua1_q;
    ub2_q   <= ub1_q;

    tot3_q  <= tot3_d;
    twa3_q  <= {sa2_q, 1'b0};
    twb3_q  <= {sb2_q, 1'b0};
    dmag3_q <= dmag3_d;
    dneg3_q <= dneg3_d;
    mua3_q  <= mua3_d;
    mub3_q  <= mub3_d;
    nua3_q  <= ua2_q[VelW-1];
    nub3_q  <= ub2_q[VelW-1];

    p1a4_q  <= p1a4_d;
    p2a4_q  <= p2a4_d;
    p1b4_q  <= p1b4_d;
    p2b4_q  <= p2b4_d;
    n1a4_q  <= dneg3_q ^ nua3_q;
    n2a4_q  <= nub3_q;
    n1b4_q  <= nua3_q;
    n2b4_q  <= (!dneg3_q && (dmag3_q != '0)) ^ nub3_q;
    zero4_q <= (tot3_q == '0);
    tot4_q  <= tot3_q;
    mua4_q  <= mua3_q;
    mub4_q  <= mub3_q;
    nua4_q  <= nua3_q;
    nub4_q  <= nub3_q;

    div5_q  <= div5_d;
  end

  assign valid_o = v5_q;
  assign div_o   = div5_q;

endmodule

### src/ecv_div.sv
// ----------------------------------------------------------------------------
// ecv_div
// Restoring divider for both numerators, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ecv_pkg::ecv_div_t work_i,
  output logic              valid_o,
  output ecv_pkg::ecv_div_t work_o
);
  import ecv_pkg::*;

  // one trial subtract of den shifted left by sh, result {qbit, rem}
  function automatic logic [NumW:0] div_step(logic [NumW-1:0] rem,
                                             logic [TotW-1:0] den,
                                             int unsigned     sh);
    logic [NumW-1:0] dsh;
    logic [NumW:0]   r;
    dsh = NumW'(den) << sh;
    if (rem >= dsh) begin
      r = {1'b1, rem - dsh};
    end else begin
      r = {1'b0, rem};
    end
    return r;
  endfunction

  logic     vld_q [QuoW];
  ecv_div_t wk_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int unsigned Sh = QuoW - 1 - k;
    logic          in_v;
    ecv_div_t      in_w, out_w;
    logic [NumW:0] st_a, st_b;

    if (k == 0) begin : g_first
      assign in_v = valid_i;
      assign in_w = work_i;
    end else begin : g_next
      assign in_v = vld_q[k-1];
      assign in_w = wk_q[k-1];
    end

    assign st_a = div_step(in_w.rem_a, in_w.den, Sh);
    assign st_b = div_step(in_w.rem_b, in_w.den, Sh);

    always_comb begin
      out_w           = in_w;
      out_w.rem_a     = st_a[NumW-1:0];
      out_w.rem_b     = st_b[NumW-1:0];
      out_w.quo_a[Sh] = st_a[NumW];
      out_w.quo_b[Sh] = st_b[NumW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      wk_q[k] <= out_w;
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign work_o  = wk_q[QuoW-1];

endmodule

### src/ecv_sat.sv
// ----------------------------------------------------------------------------
// ecv_sat
// Sign restore, saturation and the result register.
// ----------------------------------------------------------------------------
module ecv_sat (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ecv_pkg::ecv_div_t work_i,
  output logic              done_o,
  output ecv_pkg::ecv_out_t result_o
);
  import ecv_pkg::*;

  // {clip, value}
  function automatic logic [VelW:0] sat(logic neg, logic [QuoW-1:0] q);
    logic [VelW:0] r;
    if (neg) begin
      if (q > LimNeg) begin
        r = {1'b1, VelMin};
      end else begin
        r = {1'b0, VelW'(~q + QuoW'(1))};
      end
    end else begin
      if (q > LimPos) begin
        r = {1'b1, VelMax};
      end else begin
        r = {1'b0, q[VelW-1:0]};
      end
    end
    return r;
  endfunction

  logic [VelW:0] sat_a, sat_b;
  ecv_out_t      res_d, res_q;
  logic          done_q;

  assign sat_a = sat(work_i.neg_a, work_i.quo_a);
  assign sat_b = sat(work_i.neg_b, work_i.quo_b);

  always_comb begin
    res_d.new_vel_a = sat_a[VelW-1:0];
    res_d.new_vel_b = sat_b[VelW-1:0];
    res_d.clipped   = sat_a[VelW] | sat_b[VelW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### src/elastic_collision_velocity_top.sv
// ----------------------------------------------------------------------------
// elastic_collision_velocity_top
// One-dimensional elastic collision of two square bodies on a chosen axis.
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload     accepted when
//   -------   --------------   ---------   ---------------------------------
//   item in   start / busy     item_i      start high and busy low at clk edge
//   result    done_o (strobe)  result_o    edge that ends the done_o cycle
//
// One item per cycle, every cycle; busy stays low.
// From accept to done_o an item passes five front stages (select,
// square, add, multiply, combine), 17 divider stages at one quotient bit
// each, and the result register. Reset clears only the valid bits; no item
// is in flight after reset. The receiver cannot stall, so nothing in the
// pipe ever waits.
//
// Masses are side lengths squared. Numerators are formed exactly in
// sign-magnitude, divided by the total mass with truncation toward zero,
// then saturated to 16 bits; clipped flags either result. When both
// masses are zero the velocities pass through unchanged.
module elastic_collision_velocity_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ecv_pkg::ecv_in_t  item_i,
  output logic              done_o,
  output ecv_pkg::ecv_out_t result_o
);
  import ecv_pkg::*;

  `include "elastic_collision_velocity_top_assert.svh"

  logic     accept;
  logic     front_vld, div_vld;
  ecv_div_t front_wk, div_wk;

  // fully pipelined, never holds an item off
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ecv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (front_vld),
    .div_o   (front_wk)
  );

  ecv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .work_i  (front_wk),
    .valid_o (div_vld),
    .work_o  (div_wk)
  );

  ecv_sat u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_vld),
    .work_i   (div_wk),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // every accepted item comes out after the fixed latency
  `ECV_ASSERT_DLY(a_item_out, accept, Latency, done_o, "accepted item not delivered")

  // no result without an item accepted the fixed latency before
  `ECV_ASSERT_IMP(a_no_phantom, done_o, $past(accept, Latency), "result without item")

  // a clipped result carries a saturated value on at least one body
  `ECV_ASSERT_IMP(a_clip_value, done_o && result_o.clipped,
    result_o.new_vel_a == VelMax || result_o.new_vel_a == VelMin ||
    result_o.new_vel_b == VelMax || result_o.new_vel_b == VelMin,
    "clipped without saturated value")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for elastic_collision_velocity_top: drives body pairs
// through the start/busy port, predicts both post-collision velocities and
// the clip flag, and compares every done_o strobe against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
  import ecv_pkg::*;

  // axis select codes carried in the func field
  localparam logic AxisX = 1'b0;
  localparam logic AxisY = 1'b1;

  localparam int NumRandom   = 1700;
  localparam int CalmFirst   = 700;   // no idling for items in [CalmFirst, CalmLast)
  localparam int CalmLast    = 1000;
  localparam int IdlePct     = 23;
  localparam int StallLimit  = 4000;  // cycles with neither an accept nor a result

  // --------------------------------------------------------------------------
  // Scoreboard: holds the expected results in order and checks each strobe.
  // --------------------------------------------------------------------------
  class velocity_scoreboard;
    ecv_out_t expected_vel_q[$];
    int       mismatch_count = 0;

    task report_mismatch(string field, longint got, longint want);
      $display("t=%0t %s mismatch: got %0d want %0d", $time, field, got, want);
      mismatch_count++;
    endtask

    // clamp a truncated quotient to the 16-bit range, flag when it bites
    function logic signed [VelW-1:0] clamp_vel(input longint q, output logic hit);
      hit = 1'b1;
      if (q > VelMax) return VelMax;
      if (q < VelMin) return VelMin;
      hit = 1'b0;
      return VelW'(q);
    endfunction

    // 1-D elastic collision, masses = side squared, exact numerators
    function ecv_out_t resolve_collision(ecv_in_t it);
      longint   ua, ub, ma, mb, mtot, num_a, num_b;
      logic     hit_a, hit_b;
      ecv_out_t r;
      ua   = (it.func == AxisY) ? it.vel_a_y : it.vel_a_x;
      ub   = (it.func == AxisY) ? it.vel_b_y : it.vel_b_x;
      ma   = longint'(it.size_a);
      mb   = longint'(it.size_b);
      ma   = ma * ma;
      mb   = mb * mb;
      mtot = ma + mb;
      if (mtot == 0) begin
        // no mass at all: velocities pass straight through
        r.new_vel_a = VelW'(ua);
        r.new_vel_b = VelW'(ub);
        r.clipped   = 1'b0;
      end else begin
        num_a = (ma - mb) * ua + 2 * mb * ub;
        num_b = 2 * ma * ua + (mb - ma) * ub;
        // SV signed division truncates toward zero
        r.new_vel_a = clamp_vel(num_a / mtot, hit_a);
        r.new_vel_b = clamp_vel(num_b / mtot, hit_b);
        r.clipped   = hit_a | hit_b;
      end
      return r;
    endfunction

    function void note_item(ecv_in_t it);
      expected_vel_q.push_back(resolve_collision(it));
    endfunction

    task check_result(ecv_out_t got);
      ecv_out_t want;
      if (expected_vel_q.size() == 0) begin
        $display("t=%0t result with no item outstanding", $time);
        mismatch_count++;
      end else begin
        want = expected_vel_q.pop_front();
        if (got.new_vel_a !== want.new_vel_a)
          report_mismatch("new_vel_a", got.new_vel_a, want.new_vel_a);
        if (got.new_vel_b !== want.new_vel_b)
          report_mismatch("new_vel_b", got.new_vel_b, want.new_vel_b);
        if (got.clipped !== want.clipped)
          report_mismatch("clipped", got.clipped, want.clipped);
      end
    endtask

    function int pending();
      return expected_vel_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input holds a known value from time zero.
  // --------------------------------------------------------------------------
  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  ecv_in_t  item_i = '0;
  logic     busy;
  logic     done_o;
  ecv_out_t result_o;

  velocity_scoreboard ledger = new();
  int                 quiet_cycles = 0;

  elastic_collision_velocity_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples pre-edge values, so it never races the NBA drives.
  // An item counts at the edge where start is high and busy low; a result
  // counts at the edge that ends its done_o cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) ledger.note_item(item_i);
      if (done_o) ledger.check_result(result_o);
    end
  end

  // Watchdog: stretches with nothing moving in either direction end the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_top failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // velocity mix: rails, near zero, and full-range random
  function automatic logic signed [VelW-1:0] rand_vel();
    case ($urandom_range(9))
      0: return VelMin;
      1: return VelMax;
      2: return VelW'($urandom_range(0, 512) - 256);
      default: return VelW'($urandom);
    endcase
  endfunction

  // side mix: zero and the rails show up often enough to pair with each other
  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return SizeW'(1);
      3: return SizeW'($urandom_range(1, 15));
      default: return SizeW'($urandom);
    endcase
  endfunction

  function automatic ecv_in_t rand_item();
    ecv_in_t it;
    it.func    = 1'($urandom);
    it.size_a  = rand_size();
    it.size_b  = rand_size();
    it.vel_a_x = rand_vel();
    it.vel_a_y = rand_vel();
    it.vel_b_x = rand_vel();
    it.vel_b_y = rand_vel();
    return it;
  endfunction

  // directed item: chosen axis gets ua/ub, the other axis random noise
  function automatic ecv_in_t mk_item(logic axis, int a, int b, int ua, int ub);
    ecv_in_t it;
    it        = rand_item();
    it.func   = axis;
    it.size_a = SizeW'(a);
    it.size_b = SizeW'(b);
    if (axis == AxisY) begin
      it.vel_a_y = VelW'(ua);
      it.vel_b_y = VelW'(ub);
    end else begin
      it.vel_a_x = VelW'(ua);
      it.vel_b_x = VelW'(ub);
    end
    return it;
  endfunction

  // Present one item and hold it until accepted; then maybe idle a while.
  // start is only lowered on idle, so back-to-back items keep it high.
  task automatic send(ecv_in_t it, bit no_idle);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rails, both axes, massless bodies, truncation, saturation
    send(mk_item(AxisX, 1, 1, 0, 0), 1'b0);
    send(mk_item(AxisX, 255, 255, 32767, -32768), 1'b0);   // equal masses swap
    send(mk_item(AxisY, 255, 255, -32768, 32767), 1'b0);
    send(mk_item(AxisX, 0, 0, -32768, 32767), 1'b0);       // no mass: pass through
    send(mk_item(AxisY, 0, 0, 1234, -1), 1'b0);
    send(mk_item(AxisX, 0, 200, 100, -300), 1'b0);         // massless first body
    send(mk_item(AxisY, 255, 0, -5000, 7000), 1'b0);       // massless second body
    send(mk_item(AxisX, 1, 255, -32768, 32767), 1'b0);     // first clips high
    send(mk_item(AxisX, 1, 255, 32767, -32768), 1'b0);     // first clips low
    send(mk_item(AxisY, 255, 1, 32767, -32768), 1'b0);     // second clips high
    send(mk_item(AxisY, 255, 1, -32768, 32767), 1'b0);     // second clips low
    send(mk_item(AxisX, 255, 0, 32767, -32768), 1'b0);
    send(mk_item(AxisX, 3, 7, -1, 1), 1'b0);               // truncation toward zero
    send(mk_item(AxisY, 2, 5, -257, 129), 1'b0);
    send(mk_item(AxisX, 255, 1, -1, -1), 1'b0);
    send(mk_item(AxisY, 128, 127, 32767, 32767), 1'b0);

    // random body pairs, with a calm stretch of back-to-back items
    for (int n = 0; n < NumRandom; n++)
      send(rand_item(), n >= CalmFirst && n < CalmLast);
    start <= 1'b0;

    // drain, then give the pipe its latency to show any stray strobe
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    if (ledger.mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
